>>> rtl/fpa_pkg.sv
// ============================================================================
// fpa_pkg
// Shared types and constants for the fixed-point amount to ASCII formatter.
// ============================================================================
`default_nettype none

package fpa_pkg;

    // Amount and decimal digit row
    localparam int AMT_W  = 64;
    localparam int NDIG   = 20;                 // decimal digits of a 64-bit value
    localparam int STEP_W = $clog2(AMT_W);
    localparam int DIDX_W = $clog2(NDIG);
    localparam int POS_W  = 7;                  // character positions and limits

    // Fraction count clamp
    localparam int          FRAC_W   = 3;
    localparam logic [2:0]  FRAC_MAX = 3'd6;

    // Token: clamped to TOKEN_CHARS and to the 8 bytes of the token register
    localparam int          TOKEN_CHARS = 8;
    localparam int          TOK_BYTES   = 8;
    localparam logic [3:0]  TOK_MAX     = (TOKEN_CHARS < TOK_BYTES) ?
                                          4'(TOKEN_CHARS) : 4'(TOK_BYTES);

    // Characters
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // Configuration register indexes
    localparam logic [1:0] REG_MAX_CHARS    = 2'd0;
    localparam logic [1:0] REG_TOKEN_TEXT   = 2'd1;
    localparam logic [1:0] REG_TOKEN_LENGTH = 2'd2;

    typedef logic [NDIG-1:0][3:0] bcd_vec_t;

    // What every digit cell does in a cycle
    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_CLEAR  = 2'd1,   // load: digits to zero, amount into binary shifter
        CELL_DABBLE = 2'd2,   // add-3 adjust and shift one bit up the row
        CELL_DSHIFT = 2'd3    // shift one whole digit up the row
    } cell_mode_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'd0,
        ST_CONV = 3'd1,
        ST_PLAN = 3'd2,
        ST_FIT  = 3'd3,
        ST_SKIP = 3'd4,
        ST_EMIT = 3'd5
    } fpa_state_t;

endpackage

`default_nettype wire

>>> rtl/fpa_bcd_cell.sv
// ============================================================================
// fpa_bcd_cell
// One decimal digit of the conversion row: shift-add-3 or whole-digit shift.
// ============================================================================
`default_nettype none

module fpa_bcd_cell (
    input  wire logic                aclk,
    input  wire fpa_pkg::cell_mode_t mode_i,
    input  wire logic                carry_i,   // bit from the lower neighbor
    input  wire logic [3:0]          digit_i,   // digit of the lower neighbor
    output logic                     carry_o,   // bit to the upper neighbor
    output logic [3:0]               digit_o
);
    import fpa_pkg::*;

    logic [3:0] digit_reg;
    logic [3:0] digit_next;
    logic [3:0] adj;

    // add 3 when the digit would overflow past 9 after doubling
    assign adj     = (digit_reg >= 4'd5) ? digit_reg + 4'd3 : digit_reg;
    assign carry_o = adj[3];
    assign digit_o = digit_reg;

    always_comb begin
        case (mode_i)
            CELL_CLEAR:  digit_next = 4'd0;
            CELL_DABBLE: digit_next = {adj[2:0], carry_i};
            CELL_DSHIFT: digit_next = digit_i;
            default:     digit_next = digit_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        digit_reg <= digit_next;
    end

endmodule

`default_nettype wire

>>> rtl/fpa_bcd_chain.sv
// ============================================================================
// fpa_bcd_chain
// Binary shifter feeding a row of digit cells; digit 0 is the units digit.
// ============================================================================
`default_nettype none

module fpa_bcd_chain (
    input  wire logic                        aclk,
    input  wire fpa_pkg::cell_mode_t         mode_i,
    input  wire logic [fpa_pkg::AMT_W-1:0]   amount_i,
    output fpa_pkg::bcd_vec_t                digits_o
);
    import fpa_pkg::*;

    logic [AMT_W-1:0] bin_reg;
    logic [AMT_W-1:0] bin_next;
    logic [NDIG:0]    carry;
    logic [3:0]       dig_in [NDIG];

    // binary source, msb first into the units cell
    always_comb begin
        case (mode_i)
            CELL_CLEAR:  bin_next = amount_i;
            CELL_DABBLE: bin_next = {bin_reg[AMT_W-2:0], 1'b0};
            default:     bin_next = bin_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        bin_reg <= bin_next;
    end

    assign carry[0] = bin_reg[AMT_W-1];

    // row of cells
    for (genvar i = 0; i < NDIG; i++) begin : g_cell
        if (i == 0) begin : g_first
            assign dig_in[i] = 4'd0;
        end else begin : g_rest
            assign dig_in[i] = digits_o[i-1];
        end

        fpa_bcd_cell u_cell (
            .aclk    (aclk),
            .mode_i  (mode_i),
            .carry_i (carry[i]),
            .digit_i (dig_in[i]),
            .carry_o (carry[i+1]),
            .digit_o (digits_o[i])
        );
    end

endmodule

`default_nettype wire

>>> rtl/fixed_point_amount_to_ascii.sv
// ============================================================================
// fixed_point_amount_to_ascii
// Prints a 64-bit amount with 0..6 fractional digits as ASCII text, one
// character per output word, optional space and token appended.
// ============================================================================
//
//  Channel  Dir  Handshake           Payload
//  -------  ---  ------------------  -------------------------------------------
//  s_       in   s_tvalid/s_tready   s_tdata: amount[63:0], fraction_digits[66:64]
//  m_       out  m_tvalid/m_tready   m_tdata: out_char[7:0]; m_tlast: last
//  cfg_     in   cfg_we              cfg_index, cfg_wdata (no read-back)
//
//  One amount at a time: accept, double-dabble of all 64 bits in the
//  digit row, planning in ST_PLAN and ST_FIT, whole-digit shifts that bring
//  the N text digits (integer and fraction) to the top of the row, then one
//  character per cycle (up to 30) while the output register is free.
//  s_tready is high only between amounts; the last character may still wait.
//  Reset (aresetn low, synchronous) clears control and loads register resets.
//  A stalled m_ side holds the word and pauses the character sequence.
//
`default_nettype none

module fixed_point_amount_to_ascii (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input words
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [71:0] s_tdata,   // [63:0] amount, [66:64] fraction_digits
    // result words
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [7:0] out_char
    output logic             m_tlast,   // last
    // configuration
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [63:0] cfg_wdata
);
    import fpa_pkg::*;

    // configuration registers
    logic [6:0]  max_chars_reg;
    logic [63:0] token_text_reg;
    logic [3:0]  token_length_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_chars_reg    <= 7'd32;
            token_text_reg   <= 64'd0;
            token_length_reg <= 4'd0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_MAX_CHARS:    max_chars_reg    <= cfg_wdata[6:0];
                REG_TOKEN_TEXT:   token_text_reg   <= cfg_wdata;
                REG_TOKEN_LENGTH: token_length_reg <= cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    // control state
    fpa_state_t       state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [DIDX_W-1:0] skip_reg, skip_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic              m_tvalid_reg, m_tvalid_next;

    // per-amount payload
    logic [FRAC_W-1:0] d_reg, d_next;
    logic [DIDX_W-1:0] nd_reg, nd_next;
    logic [POS_W-1:0]  point_reg, point_next;
    logic [POS_W-1:0]  len_txt_reg, len_txt_next;
    logic [POS_W-1:0]  total_reg, total_next;
    logic [63:0]       tok_reg, tok_next;
    logic [7:0]        m_tdata_reg, m_tdata_next;
    logic              m_tlast_reg, m_tlast_next;

    cell_mode_t mode;
    bcd_vec_t   digits;

    fpa_bcd_chain u_chain (
        .aclk     (aclk),
        .mode_i   (mode),
        .amount_i (s_tdata[AMT_W-1:0]),
        .digits_o (digits)
    );

    // planning terms
    logic [DIDX_W-1:0] sig;
    logic [DIDX_W-1:0] d_plus1;
    logic [POS_W-1:0]  d7;
    logic [POS_W-1:0]  point7;
    logic [POS_W-1:0]  n7;
    logic [POS_W-1:0]  limit7;
    logic [POS_W-1:0]  len7;
    logic [FRAC_W-1:0] fi;
    logic [FRAC_W-1:0] best;
    logic [DIDX_W-1:0] fidx;
    logic [POS_W-1:0]  txt7;
    logic [3:0]        tl;
    logic [POS_W:0]    tok_end;
    logic              tok_fit;
    logic [FRAC_W-1:0] s_frac;
    logic              out_free;
    logic              is_last;
    logic [7:0]        ch;
    logic              ch_digit;

    always_comb begin
        // significant digits of the converted amount, at least one
        sig = DIDX_W'(1);
        for (int i = 0; i < NDIG; i++) begin
            if (digits[i] != 4'd0) sig = DIDX_W'(i + 1);
        end
        d_plus1 = DIDX_W'(d_reg) + DIDX_W'(1);

        // text length before and after the cut
        d7     = POS_W'(d_reg);
        point7 = POS_W'(nd_reg) - d7;
        n7     = POS_W'(nd_reg) + ((d_reg != '0) ? POS_W'(1) : POS_W'(0));
        limit7 = (max_chars_reg < 7'd2) ? POS_W'(1) : max_chars_reg - 7'd1;
        len7   = (n7 < limit7) ? n7 : limit7;

        // strip trailing fractional zeros and a dangling point
        fi   = '0;
        best = '0;
        fidx = '0;
        txt7 = len7;
        if (d_reg != '0 && len7 > point7) begin
            fi = FRAC_W'(len7 - point7 - POS_W'(1));
            for (int f = 1; f <= int'(FRAC_MAX); f++) begin
                if (FRAC_W'(f) <= fi) begin
                    fidx = DIDX_W'(d_reg) - DIDX_W'(f);
                    if (digits[fidx] != 4'd0) best = FRAC_W'(f);
                end
            end
            txt7 = (best != '0) ? point7 + POS_W'(best) + POS_W'(1) : point7;
        end

        // token fits when text, space and token stay within the limit
        tl      = (token_length_reg > TOK_MAX) ? TOK_MAX : token_length_reg;
        tok_end = {1'b0, len_txt_reg} + (POS_W+1)'(tl) + (POS_W+1)'(1);
        tok_fit = (tl != 4'd0) && (tok_end <= {1'b0, limit7});
    end

    // character at the current position
    always_comb begin
        ch_digit = 1'b0;
        if (pos_reg < len_txt_reg) begin
            if (d_reg != '0 && pos_reg == point_reg) begin
                ch = CH_POINT;
            end else begin
                ch       = CH_ZERO + {4'd0, digits[NDIG-1]};
                ch_digit = 1'b1;
            end
        end else if (pos_reg == len_txt_reg) begin
            ch = CH_SPACE;
        end else begin
            ch = tok_reg[7:0];
        end
    end

    assign s_frac   = (s_tdata[66:64] > FRAC_MAX) ? FRAC_MAX : s_tdata[66:64];
    assign out_free = !m_tvalid_reg || m_tready;
    assign is_last  = (pos_reg == total_reg - POS_W'(1));

    // next state and outputs
    always_comb begin
        state_next    = state_reg;
        step_next     = step_reg;
        skip_next     = skip_reg;
        pos_next      = pos_reg;
        d_next        = d_reg;
        nd_next       = nd_reg;
        point_next    = point_reg;
        len_txt_next  = len_txt_reg;
        total_next    = total_reg;
        tok_next      = tok_reg;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        mode          = CELL_HOLD;
        s_tready      = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    mode       = CELL_CLEAR;
                    d_next     = s_frac;
                    step_next  = '0;
                    state_next = ST_CONV;
                end
            end
            ST_CONV: begin
                mode      = CELL_DABBLE;
                step_next = step_reg + STEP_W'(1);
                if (step_reg == '1) state_next = ST_PLAN;
            end
            ST_PLAN: begin
                nd_next    = (sig > d_plus1) ? sig : d_plus1;
                state_next = ST_FIT;
            end
            ST_FIT: begin
                point_next   = point7;
                len_txt_next = txt7;
                total_next   = txt7;
                skip_next    = DIDX_W'(NDIG) - nd_reg;
                tok_next     = token_text_reg;
                pos_next     = '0;
                state_next   = ST_SKIP;
            end
            ST_SKIP: begin
                // the token decision needs the stripped length, now registered
                if (tok_fit) total_next = tok_end[POS_W-1:0];
                if (skip_reg == '0) begin
                    state_next = ST_EMIT;
                end else begin
                    mode      = CELL_DSHIFT;
                    skip_next = skip_reg - DIDX_W'(1);
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = ch;
                    m_tlast_next  = is_last;
                    pos_next      = pos_reg + POS_W'(1);
                    if (ch_digit) mode = CELL_DSHIFT;
                    if (pos_reg > len_txt_reg) tok_next = {8'd0, tok_reg[63:8]};
                    if (is_last) state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            step_reg     <= '0;
            skip_reg     <= '0;
            pos_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            step_reg     <= step_next;
            skip_reg     <= skip_next;
            pos_reg      <= pos_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        d_reg       <= d_next;
        nd_reg      <= nd_next;
        point_reg   <= point_next;
        len_txt_reg <= len_txt_next;
        total_reg   <= total_next;
        tok_reg     <= tok_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

`default_nettype wire

>>> rtl/fpa_checker.sv
// ============================================================================
// fpa_checker
// Port-level checks for the amount formatter, bound to the top level.
// ============================================================================
`default_nettype none

module fpa_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_tvalid,
    input wire logic       s_tready,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic       m_tlast
);

    // output register comes out of reset empty
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("word valid right after reset");

    // a new amount is never taken while a non-final character waits
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tlast) |-> !s_tready)
        else $error("input ready in the middle of a text");

    // the formatter is busy right after taking an amount
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input ready right after accept");

    // a stalled result word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("stalled result word changed");

endmodule

bind fixed_point_amount_to_ascii fpa_checker u_fpa_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire

>>> tb/amount_text_checker.sv
`timescale 1ns / 100ps
// ============================================================================
// amount_text_checker
// Scoreboard for the amount formatter. Mirrors the configuration writes,
// predicts the character words of every accepted amount and compares each
// result word, in order, against the oldest prediction.
// ============================================================================

module amount_text_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [71:0] s_tdata,   // [63:0] amount, [66:64] fraction_digits
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,   // [7:0] out_char
    input  logic        m_tlast,   // last
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_wdata,
    output int unsigned fail_count,
    output int unsigned pending
);

    typedef struct {
        logic [7:0]  ch;
        logic        last;
        int unsigned item;
    } char_word_t;

    // Shadow copy of the configuration registers
    logic [6:0]  max_chars_q;
    logic [63:0] token_text_q;
    logic [3:0]  token_len_q;

    char_word_t  expected_chars[$];
    int unsigned amounts_seen;

    initial begin
        fail_count   = 0;
        pending      = 0;
        amounts_seen = 0;
    end

    task automatic report_mismatch(input string what);
        $display("ERROR @%0t: %s", $time, what);
        fail_count++;
    endtask

    function automatic logic [63:0] pow10(input int e);
        logic [63:0] p;
        p = 64'd1;
        for (int i = 0; i < e; i++)
            p = p * 64'd10;
        return p;
    endfunction

    // Expected text of one amount under the current configuration
    task automatic predict_text(input logic [63:0] amount, input logic [2:0] frac_in);
        logic [7:0]  text [0:63];
        logic [7:0]  rev [0:23];
        logic [63:0] scale, int_part, frac_part;
        int          n, k, len, limit, point, tl, frac;
        char_word_t  w;
        n     = 0;
        k     = 0;
        point = 0;
        frac  = (frac_in > fpa_pkg::FRAC_MAX) ? int'(fpa_pkg::FRAC_MAX) : int'(frac_in);
        scale     = pow10(frac);
        int_part  = amount / scale;
        frac_part = amount % scale;

        // integer digits, at least one
        while (k == 0 || int_part != 0) begin
            rev[k]   = fpa_pkg::CH_ZERO + 8'(int_part % 64'd10);
            k++;
            int_part = int_part / 64'd10;
        end
        while (k > 0) begin
            k--;
            text[n] = rev[k];
            n++;
        end

        // point and fractional digits
        if (frac > 0) begin
            point   = n;
            text[n] = fpa_pkg::CH_POINT;
            n++;
            for (int i = frac; i > 0; i--) begin
                text[n] = fpa_pkg::CH_ZERO + 8'((frac_part / pow10(i - 1)) % 64'd10);
                n++;
            end
        end

        // cut to the destination, then strip fractional zeros and a bare point
        limit = (max_chars_q < 7'd2) ? 1 : int'(max_chars_q) - 1;
        len   = (n < limit) ? n : limit;
        if (frac > 0 && len > point) begin
            while (len > point + 1 && text[len-1] == fpa_pkg::CH_ZERO)
                len--;
            if (text[len-1] == fpa_pkg::CH_POINT)
                len--;
        end

        // token, only when it fits entirely
        tl = (token_len_q > fpa_pkg::TOK_MAX) ? int'(fpa_pkg::TOK_MAX) : int'(token_len_q);
        if (tl > 0 && len + tl + 1 < limit + 1) begin
            text[len] = fpa_pkg::CH_SPACE;
            len++;
            for (int i = 0; i < tl; i++) begin
                text[len] = token_text_q[8*i +: 8];
                len++;
            end
        end

        for (int i = 0; i < len; i++) begin
            w.ch   = text[i];
            w.last = (i + 1 == len);
            w.item = amounts_seen;
            expected_chars.push_back(w);
        end
    endtask

    // Watch all three channels on the rising edge
    always @(posedge aclk) begin
        char_word_t want;
        if (!aresetn) begin
            max_chars_q  = 7'd32;
            token_text_q = 64'd0;
            token_len_q  = 4'd0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    fpa_pkg::REG_MAX_CHARS:    max_chars_q  = cfg_wdata[6:0];
                    fpa_pkg::REG_TOKEN_TEXT:   token_text_q = cfg_wdata;
                    fpa_pkg::REG_TOKEN_LENGTH: token_len_q  = cfg_wdata[3:0];
                    default: ;
                endcase
            end

            // result word against the oldest prediction
            if (m_tvalid && m_tready) begin
                if (expected_chars.size() == 0) begin
                    report_mismatch($sformatf("unexpected word char 0x%02h last %0b",
                                              m_tdata, m_tlast));
                end else begin
                    want = expected_chars.pop_front();
                    if (m_tdata !== want.ch)
                        report_mismatch($sformatf("amount %0d: char 0x%02h, want 0x%02h",
                                                  want.item, m_tdata, want.ch));
                    if (m_tlast !== want.last)
                        report_mismatch($sformatf("amount %0d: last %0b, want %0b",
                                                  want.item, m_tlast, want.last));
                end
            end

            if (s_tvalid && s_tready) begin
                predict_text(s_tdata[63:0], s_tdata[66:64]);
                amounts_seen++;
            end
        end
        pending = expected_chars.size();
    end

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// ============================================================================
// tb
// Stimulus and verdict for the fixed-point amount to ASCII formatter.
// Directed amounts hit zero, the largest value, clamped fraction counts,
// zero stripping and cuts before the point; random amounts then run under
// several configurations, with bursty input and a stalling output side.
// ============================================================================

module tb;

    localparam int          WATCHDOG_LIMIT = 4000;
    localparam int          DRAIN_CYCLES   = 150;
    localparam logic [1:0]  REG_UNUSED     = 2'd3;
    localparam logic [63:0] ALL_ONES       = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef enum logic [1:0] {
        RX_OPEN   = 2'd0,   // always ready
        RX_COIN   = 2'd1,   // ready half the time
        RX_SPARSE = 2'd2,   // rare single-cycle stalls
        RX_LONG   = 2'd3    // occasional long stalls
    } rx_mode_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata   = '0;    // [63:0] amount, [66:64] fraction_digits
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;           // [7:0] out_char
    logic        m_tlast;           // last
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [63:0] cfg_wdata = '0;

    int unsigned fail_count;
    int unsigned pending;
    int unsigned idle_cycles = 0;
    int unsigned burst_left  = 0;

    rx_mode_t    rx_mode    = RX_OPEN;
    int unsigned mode_left  = 0;
    int unsigned stall_left = 0;

    fixed_point_amount_to_ascii dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    amount_text_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // 10 ns clock
    initial begin
        forever #5 aclk = ~aclk;
    end

    // Output side: stall pattern switches between the four modes at random
    always @(negedge aclk) begin
        if (mode_left == 0) begin
            rx_mode   = rx_mode_t'($urandom_range(0, 3));
            mode_left = $urandom_range(20, 300);
        end else begin
            mode_left--;
        end
        case (rx_mode)
            RX_OPEN:   m_tready = 1'b1;
            RX_COIN:   m_tready = 1'($urandom_range(0, 1));
            RX_SPARSE: m_tready = ($urandom_range(0, 7) != 0);
            default: begin
                if (stall_left > 0) begin
                    m_tready = 1'b0;
                    stall_left--;
                end else begin
                    m_tready = 1'b1;
                    if ($urandom_range(0, 5) == 0)
                        stall_left = $urandom_range(5, 40);
                end
            end
        endcase
    end

    // Watchdog: cycles in which no word moves on either channel
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("fixed_point_amount_to_ascii: mismatch");
            $finish;
        end
    end

    // One input word; the sender runs in bursts with random gaps between
    task automatic send_amount(input logic [63:0] amount, input logic [2:0] frac);
        int unsigned gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 150)
                                                     : $urandom_range(0, 4);
            burst_left = $urandom_range(1, 12);
            if (gap > 0) begin
                @(negedge aclk);
                s_tvalid = 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
        burst_left--;
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tdata  = {5'b0, frac, amount};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Stop sending and wait for every predicted word to arrive
    task automatic drain();
        @(negedge aclk);
        s_tvalid   = 1'b0;
        burst_left = 0;
        while (pending != 0) @(negedge aclk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [63:0] data);
        @(negedge aclk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = data;
        @(posedge aclk);
    endtask

    // Idle first, then all three registers; unused high bits carry noise
    task automatic set_config(input logic [6:0] mc, input logic [63:0] tok,
                              input logic [3:0] tlen);
        drain();
        cfg_write(fpa_pkg::REG_MAX_CHARS,
                  {$urandom, 22'($urandom_range(0, 1023)), 3'b0, mc});
        cfg_write(fpa_pkg::REG_TOKEN_TEXT, tok);
        cfg_write(fpa_pkg::REG_TOKEN_LENGTH,
                  {$urandom, 28'($urandom_range(0, 4095)), tlen});
        @(negedge aclk);
        cfg_we = 1'b0;
    endtask

    // Mix of full-range, small, zero-heavy and near-maximum amounts
    function automatic logic [63:0] random_amount();
        logic [63:0] v;
        case ($urandom_range(0, 5))
            0: v = {$urandom, $urandom};
            1: v = 64'($urandom_range(0, 999));
            2: begin
                v = 64'($urandom_range(1, 9999));
                repeat ($urandom_range(0, 12)) v = v * 64'd10;
            end
            3: v = ALL_ONES - 64'($urandom_range(0, 1000));
            4: v = {$urandom, $urandom} >> $urandom_range(0, 63);
            default: v = 64'($urandom);
        endcase
        return v;
    endfunction

    task automatic run_phase(input logic [6:0] mc, input logic [63:0] tok,
                             input logic [3:0] tlen, input int count);
        set_config(mc, tok, tlen);
        repeat (count) send_amount(random_amount(), 3'($urandom_range(0, 7)));
    endtask

    initial begin
        repeat (5) @(negedge aclk);
        aresetn = 1'b1;

        // a write to the unused index must change nothing
        cfg_write(REG_UNUSED, ALL_ONES);
        @(negedge aclk);
        cfg_we = 1'b0;

        // directed, reset configuration: zero, maximum, clamp, stripping
        send_amount(64'd0, 3'd0);
        send_amount(64'd0, 3'd3);
        send_amount(64'd0, 3'd7);
        send_amount(ALL_ONES, 3'd0);
        send_amount(ALL_ONES, 3'd6);
        send_amount(ALL_ONES, 3'd7);
        send_amount(64'd1_000_000, 3'd6);
        send_amount(64'd1_230_000, 3'd6);
        send_amount(64'd5, 3'd1);
        send_amount(64'd100, 3'd2);
        send_amount(64'd1050, 3'd2);
        send_amount(64'd7, 3'd5);
        send_amount(64'd123_456_789_012, 3'd4);
        send_amount(64'h8000_0000_0000_0000, 3'd2);

        // token that fits behind the longest text
        set_config(7'd64, 64'h0000_0000_0048_5445, 4'd3);
        send_amount(ALL_ONES, 3'd6);
        send_amount(64'd0, 3'd0);
        send_amount(64'd250, 3'd4);

        // tight destination: cut before the point, cut inside fractional zeros
        set_config(7'd5, 64'h4142_4344_4546_4748, 4'd8);
        send_amount(64'd123_456_789, 3'd2);
        send_amount(64'd12_000, 3'd3);
        send_amount(64'd9, 3'd6);
        set_config(7'd7, 64'h0000_0000_0000_0058, 4'd1);
        send_amount(64'd12, 3'd0);
        send_amount(64'd123, 3'd0);

        // random part across several settings, extremes among them
        run_phase(7'd2, {$urandom, $urandom}, 4'd8, 12);
        run_phase(7'd0, {$urandom, $urandom}, 4'd15, 8);
        run_phase(7'd1, {$urandom, $urandom}, 4'd9, 8);
        run_phase(7'd127, 64'h4100_5400_4F4B_0042, 4'd8, 25);
        run_phase(7'd64, {$urandom, $urandom}, 4'd0, 15);
        run_phase(7'd32, 64'h0000_0000_0044_5355, 4'd3, 20);
        repeat (4)
            run_phase(7'($urandom_range(2, 30)), {$urandom, $urandom},
                      4'($urandom_range(0, 15)), 10);

        drain();
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (fail_count == 0)
            $display("fixed_point_amount_to_ascii: match");
        else
            $display("fixed_point_amount_to_ascii: mismatch");
        $finish;
    end

endmodule

>>> filelist.f
rtl/fpa_pkg.sv
rtl/fpa_bcd_cell.sv
rtl/fpa_bcd_chain.sv
rtl/fixed_point_amount_to_ascii.sv
rtl/fpa_checker.sv
tb/amount_text_checker.sv
tb/tb.sv
